@@ hdl/ovps_pkg.sv @@
// Shared types, constants and helpers for the Ogg page scanner.
// No dependencies; used by every module of the block.
package ovps_pkg;

	// Scanner phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_VERSION = 5'b00010,
		PH_HEADER  = 5'b00100,
		PH_SEGS    = 5'b01000,
		PH_BODY    = 5'b10000
	} phase_t;

	// Report status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_ID      = 2'd1;
	localparam logic [1:0] ST_ZERO_PARAM = 2'd2;

	// Capture pattern "OggS": first three bytes and the last one
	localparam logic [23:0] CAPTURE_PREFIX = 24'h4F6767;
	localparam logic [7:0]  CAPTURE_LAST   = 8'h53;

	// Header layout
	localparam logic [4:0] HDR_FIRST_IDX   = 5'd5;   // first byte after version
	localparam logic [4:0] GRANULE_LO_IDX  = 5'd6;
	localparam logic [4:0] GRANULE_HI_IDX  = 5'd13;
	localparam logic [4:0] SEG_COUNT_IDX   = 5'd26;  // last header byte

	// Identification packet layout within the body
	localparam logic [15:0] ID_MARKER_LEN  = 16'd7;
	localparam logic [15:0] ID_CHAN_IDX    = 16'd11;
	localparam logic [15:0] ID_RATE_LO_IDX = 16'd12;
	localparam logic [15:0] ID_RATE_HI_IDX = 16'd15;
	localparam logic [15:0] ID_MIN_BODY    = 16'd16;

	// One input transaction held in the input register
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} byte_t;

	// One report
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  channel_count;
		logic [31:0] sample_rate;
		logic [62:0] total_samples;
		logic        total_known;
	} result_t;

	// Identification marker 0x01 "vorbis"
	function automatic logic [7:0] id_marker_byte(input logic [2:0] idx);
		logic [7:0] val;
		case (idx)
			3'd0:    val = 8'h01;
			3'd1:    val = 8'h76;
			3'd2:    val = 8'h6F;
			3'd3:    val = 8'h72;
			3'd4:    val = 8'h62;
			3'd5:    val = 8'h69;
			3'd6:    val = 8'h73;
			default: val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

@@ hdl/ovps_in_stage.sv @@
// Input register for the byte stream, with ready derived from downstream advance.
// Uses ovps_pkg::byte_t.
module ovps_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ovps_pkg::byte_t in_byte,
	input  logic            advance,
	output logic            valid_s1,
	output ovps_pkg::byte_t byte_s1
);

	logic valid_q;

	// Free when empty or when the held byte moves on this cycle
	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

@@ hdl/ovps_parser.sv @@
// Page parser state: capture hunt, header, segment table, body, commit.
// Uses ovps_pkg types, constants and the marker table.
module ovps_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  ovps_pkg::byte_t   byte_s1,
	output ovps_pkg::result_t result
);

	ovps_pkg::phase_t phase_q, phase_d;
	logic [23:0] window_q, window_d;
	logic [4:0]  hidx_q, hidx_d;
	logic [7:0]  segcnt_q, segcnt_d;
	logic [7:0]  segseen_q, segseen_d;
	logic [15:0] blen_q, blen_d;
	logic [15:0] bseen_q, bseen_d;
	logic [63:0] gran_q, gran_d;
	logic        idok_q, idok_d;
	logic [7:0]  pch_q, pch_d;
	logic [31:0] prate_q, prate_d;
	logic        idfound_q, idfound_d;
	logic [7:0]  kch_q, kch_d;
	logic [31:0] krate_q, krate_d;
	logic [62:0] ktot_q, ktot_d;
	logic        ktval_q, ktval_d;
	logic        start_body, commit;
	logic [4:0]  glane;
	logic [7:0]  b;

	assign b     = byte_s1.data;
	assign glane = hidx_q - ovps_pkg::GRANULE_LO_IDX;

	// Next-state logic for one byte
	always_comb begin
		phase_d    = phase_q;
		window_d   = window_q;
		hidx_d     = hidx_q;
		segcnt_d   = segcnt_q;
		segseen_d  = segseen_q;
		blen_d     = blen_q;
		bseen_d    = bseen_q;
		gran_d     = gran_q;
		idok_d     = idok_q;
		pch_d      = pch_q;
		prate_d    = prate_q;
		idfound_d  = idfound_q;
		kch_d      = kch_q;
		krate_d    = krate_q;
		ktot_d     = ktot_q;
		ktval_d    = ktval_q;
		start_body = 1'b0;
		commit     = 1'b0;

		case (phase_q)
			ovps_pkg::PH_VERSION: begin
				if (b == 8'd0) begin
					phase_d = ovps_pkg::PH_HEADER;
					hidx_d  = ovps_pkg::HDR_FIRST_IDX;
					gran_d  = 64'd0;
				end else begin
					phase_d  = ovps_pkg::PH_HUNT;
					window_d = {16'd0, b};
				end
			end
			ovps_pkg::PH_HEADER: begin
				if (hidx_q >= ovps_pkg::GRANULE_LO_IDX && hidx_q <= ovps_pkg::GRANULE_HI_IDX) begin
					gran_d[{glane[2:0], 3'b000} +: 8] = b;
				end
				if (hidx_q >= ovps_pkg::SEG_COUNT_IDX) begin
					segcnt_d  = b;
					segseen_d = 8'd0;
					blen_d    = 16'd0;
					if (b == 8'd0) begin
						start_body = 1'b1;
					end else begin
						phase_d = ovps_pkg::PH_SEGS;
					end
				end else begin
					hidx_d = hidx_q + 5'd1;
				end
			end
			ovps_pkg::PH_SEGS: begin
				blen_d    = blen_q + {8'd0, b};
				segseen_d = segseen_q + 8'd1;
				if (segseen_d >= segcnt_q) begin
					start_body = 1'b1;
				end
			end
			ovps_pkg::PH_BODY: begin
				if (bseen_q < ovps_pkg::ID_MARKER_LEN &&
				    b != ovps_pkg::id_marker_byte(bseen_q[2:0])) begin
					idok_d = 1'b0;
				end
				if (bseen_q == ovps_pkg::ID_CHAN_IDX) begin
					pch_d = b;
				end
				if (bseen_q >= ovps_pkg::ID_RATE_LO_IDX && bseen_q <= ovps_pkg::ID_RATE_HI_IDX) begin
					prate_d[{bseen_q[1:0], 3'b000} +: 8] = b;
				end
				bseen_d = bseen_q + 16'd1;
				if (bseen_d >= blen_q) begin
					commit = 1'b1;
				end
			end
			default: begin
				// Hunting, also for any stray phase code
				phase_d = ovps_pkg::PH_HUNT;
				if (window_q == ovps_pkg::CAPTURE_PREFIX && b == ovps_pkg::CAPTURE_LAST) begin
					phase_d  = ovps_pkg::PH_VERSION;
					window_d = 24'd0;
				end else begin
					window_d = {window_q[15:0], b};
				end
			end
		endcase

		// Segment table done: set up body capture
		if (start_body) begin
			bseen_d = 16'd0;
			idok_d  = 1'b1;
			pch_d   = 8'd0;
			prate_d = 32'd0;
			if (blen_d == 16'd0) begin
				commit = 1'b1;
			end else begin
				phase_d = ovps_pkg::PH_BODY;
			end
		end

		// Complete page: keep granule and first identification
		if (commit) begin
			if (gran_d != 64'd0 && !gran_d[63]) begin
				ktot_d  = gran_d[62:0];
				ktval_d = 1'b1;
			end
			if (!idfound_q && idok_d && blen_d >= ovps_pkg::ID_MIN_BODY) begin
				kch_d     = pch_d;
				krate_d   = prate_d;
				idfound_d = 1'b1;
			end
			phase_d  = ovps_pkg::PH_HUNT;
			window_d = 24'd0;
		end
	end

	// Report from the state after this byte
	always_comb begin
		if (!idfound_d) begin
			result.status = ovps_pkg::ST_NO_ID;
		end else if (kch_d == 8'd0 || krate_d == 32'd0) begin
			result.status = ovps_pkg::ST_ZERO_PARAM;
		end else begin
			result.status = ovps_pkg::ST_OK;
		end
		result.channel_count = kch_d;
		result.sample_rate   = krate_d;
		result.total_samples = ktval_d ? ktot_d : 63'd0;
		result.total_known   = ktval_d;
	end

	// State registers; the end of a stream returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= ovps_pkg::PH_HUNT;
			window_q  <= '0;
			hidx_q    <= '0;
			segcnt_q  <= '0;
			segseen_q <= '0;
			blen_q    <= '0;
			bseen_q   <= '0;
			gran_q    <= '0;
			idok_q    <= 1'b0;
			pch_q     <= '0;
			prate_q   <= '0;
			idfound_q <= 1'b0;
			kch_q     <= '0;
			krate_q   <= '0;
			ktot_q    <= '0;
			ktval_q   <= 1'b0;
		end else if (advance) begin
			if (byte_s1.last) begin
				phase_q   <= ovps_pkg::PH_HUNT;
				window_q  <= '0;
				hidx_q    <= '0;
				segcnt_q  <= '0;
				segseen_q <= '0;
				blen_q    <= '0;
				bseen_q   <= '0;
				gran_q    <= '0;
				idok_q    <= 1'b0;
				pch_q     <= '0;
				prate_q   <= '0;
				idfound_q <= 1'b0;
				kch_q     <= '0;
				krate_q   <= '0;
				ktot_q    <= '0;
				ktval_q   <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				window_q  <= window_d;
				hidx_q    <= hidx_d;
				segcnt_q  <= segcnt_d;
				segseen_q <= segseen_d;
				blen_q    <= blen_d;
				bseen_q   <= bseen_d;
				gran_q    <= gran_d;
				idok_q    <= idok_d;
				pch_q     <= pch_d;
				prate_q   <= prate_d;
				idfound_q <= idfound_d;
				kch_q     <= kch_d;
				krate_q   <= krate_d;
				ktot_q    <= ktot_d;
				ktval_q   <= ktval_d;
			end
		end
	end

endmodule

@@ hdl/ovps_out_stage.sv @@
// Result register holding one report until the receiver takes it.
// Uses ovps_pkg::result_t.
module ovps_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ovps_pkg::result_t result,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              free,
	output ovps_pkg::result_t result_s2
);

	logic valid_q;

	assign out_valid = valid_q;
	assign free      = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

endmodule

@@ hdl/ogg_vorbis_page_scanner_top.sv @@
// Ogg page scanner with Vorbis identification pickup: top level.
// Depends on ovps_pkg, ovps_in_stage, ovps_parser, ovps_out_stage.
//
// Usage:
//   Bytes of an Ogg stream enter on the s_axis channel, one per transaction;
//   s_axis_tlast marks the final byte of a stream. The scanner finds pages,
//   reads header, segment table and body, and keeps the granule position and
//   Vorbis channel count and sample rate of complete pages only.
//   After the tlast byte, one report leaves on the m_axis channel; then all
//   state returns to its reset values and the next byte starts a new stream.
//   Throughput: one byte per cycle while no tlast byte waits for the output
//   register; each byte passes the input register and then the parser logic.
//   The report enters the output register as the tlast byte leaves the parser.
//   Stall: the output register holds the report while m_axis_tready is low;
//   bytes keep flowing until a second tlast byte reaches the parser, which then
//   waits in the input register and drops s_axis_tready.
//   Reset: arst_n clears the scanner state and both valid flags at once;
//   no result is pending and the scanner is hunting for a capture pattern.
module ogg_vorbis_page_scanner_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // end_of_stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,   // [1:0] status, [9:2] channel_count,
	                                     // [41:10] sample_rate, [104:42] total_samples,
	                                     // [111:105] zero
	output logic         m_axis_tuser    // total_known
);

	ovps_pkg::byte_t   in_byte, byte_s1;
	ovps_pkg::result_t result, result_s2;
	logic valid_s1, advance, out_free;

	assign in_byte.data = s_axis_tdata;
	assign in_byte.last = s_axis_tlast;

	// Move the held byte unless it would produce a report with no room for it
	assign advance = valid_s1 && (!byte_s1.last || out_free);

	ovps_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (in_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	ovps_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.result  (result)
	);

	ovps_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && byte_s1.last),
		.result    (result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.free      (out_free),
		.result_s2 (result_s2)
	);

	assign m_axis_tdata = {7'd0, result_s2.total_samples, result_s2.sample_rate,
	                       result_s2.channel_count, result_s2.status};
	assign m_axis_tuser = result_s2.total_known;

	// A held byte that cannot move stays held
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register lost a byte");

	// A report is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance && byte_s1.last |-> !m_axis_tvalid || m_axis_tready)
		else $error("report overwritten");

	// Status ok only with nonzero parameters
	a_ok_params: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && result_s2.status == ovps_pkg::ST_OK |->
		result_s2.channel_count != 8'd0 && result_s2.sample_rate != 32'd0)
		else $error("ok status with zero parameter");

	// Without identification no parameters are reported
	a_no_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && result_s2.status == ovps_pkg::ST_NO_ID |->
		result_s2.channel_count == 8'd0 && result_s2.sample_rate == 32'd0)
		else $error("parameters without identification");

	// Unknown total reads as zero
	a_total_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !result_s2.total_known |-> result_s2.total_samples == 63'd0)
		else $error("total reported while unknown");

endmodule

@@ tb/tb_ogg_vorbis_page_scanner_top.sv @@
// Self-checking testbench for the Ogg page scanner top level.
// Depends on ovps_pkg and ogg_vorbis_page_scanner_top; drives byte streams and
// checks each report against a cycle-free scanner model or a directed row's want.
module tb_ogg_vorbis_page_scanner_top;
	import ovps_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RAND_STREAMS = 40;
	localparam int RAND_BYTES   = 800;
	localparam int PRINT_CAP    = 40;

	// Identification marker 0x01 "vorbis", first byte in the lowest bits
	localparam logic [55:0] VORBIS_TAG = {"sibrov", 8'h01};

	localparam result_t NO_WANT      = '0;
	localparam result_t EMPTY_STREAM = {ST_NO_ID, 8'd0, 32'd0, 63'd0, 1'b0};

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_valid = 1'b0;
	logic [7:0]   s_data = 8'h00;
	logic         s_last = 1'b0;
	logic         s_ready;
	logic         m_valid;
	logic         m_ready = 1'b0;
	logic [111:0] m_data;
	logic         m_user;

	ogg_vorbis_page_scanner_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.s_axis_tlast  (s_last),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.m_axis_tuser  (m_user)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Directed streams: each row adds noise and/or one page to the stream being
	// built; a row with ends set sends it with tlast on its final byte.
	typedef struct {
		int          junk;     // random bytes in front
		bit          bad_ver;  // "OggS" with version 'O' first, page reuses that 'O'
		bit          page;
		logic [63:0] gran;
		int          nseg;
		int          seg;      // every lacing value
		bit          id_pkt;
		logic [7:0]  chans;
		logic [31:0] rate;
		int          cut;      // bytes dropped from the end
		int          tail;     // random bytes after the page
		bit          ends;
		bit          typed;
		result_t     want;
	} case_row_t;

	case_row_t plan [19] = '{
		// one-byte stream
		'{1, 0, 0, 64'd0, 0, 0, 0, 8'd0, 32'd0, 0, 0, 1, 1, EMPTY_STREAM},
		// id page, then a plain page closes the stream on its last byte
		'{0, 0, 1, 64'd0, 1, 30, 1, 8'd2, 32'd44100, 0, 0, 0, 0, NO_WANT},
		'{0, 0, 1, 64'd1000, 2, 10, 0, 8'd0, 32'd0, 0, 0, 1, 1,
			{ST_OK, 8'd2, 32'd44100, 63'd1000, 1'b1}},
		// largest positive granule, widest channel and rate, body of exactly 16
		'{0, 0, 1, 64'h7FFF_FFFF_FFFF_FFFF, 1, 16, 1, 8'd255, 32'hFFFF_FFFF, 0, 0, 1, 1,
			{ST_OK, 8'd255, 32'hFFFF_FFFF, {63{1'b1}}, 1'b1}},
		// empty bodies; negative granule is not kept
		'{0, 0, 1, 64'd500, 0, 0, 0, 8'd0, 32'd0, 0, 0, 0, 0, NO_WANT},
		'{0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, 3, 0, 0, 8'd0, 32'd0, 0, 0, 1, 1,
			{ST_NO_ID, 8'd0, 32'd0, 63'd500, 1'b1}},
		// identification body one byte short
		'{0, 0, 1, 64'd0, 1, 15, 1, 8'd2, 32'd48000, 0, 0, 1, 1, EMPTY_STREAM},
		// zero channels, then zero rate
		'{0, 0, 1, 64'd0, 1, 20, 1, 8'd0, 32'd8000, 0, 0, 1, 1,
			{ST_ZERO_PARAM, 8'd0, 32'd8000, 63'd0, 1'b0}},
		'{0, 0, 1, 64'd0, 1, 20, 1, 8'd1, 32'd0, 0, 0, 1, 1,
			{ST_ZERO_PARAM, 8'd1, 32'd0, 63'd0, 1'b0}},
		// stream ends inside the body
		'{0, 0, 1, 64'd77, 1, 20, 1, 8'd2, 32'd44100, 5, 0, 1, 1, EMPTY_STREAM},
		// wrong version whose byte starts the next capture pattern
		'{0, 1, 1, 64'd9, 0, 0, 0, 8'd0, 32'd0, 0, 2, 1, 0, NO_WANT},
		// only the first identification counts
		'{0, 0, 1, 64'd0, 1, 16, 1, 8'd6, 32'd96000, 0, 0, 0, 0, NO_WANT},
		'{0, 0, 1, 64'd12345, 1, 40, 1, 8'd1, 32'd22050, 0, 0, 1, 1,
			{ST_OK, 8'd6, 32'd96000, 63'd12345, 1'b1}},
		// full segment table
		'{3, 0, 1, 64'h0123_4567_89AB_CDEF, 255, 1, 0, 8'd0, 32'd0, 0, 0, 1, 0, NO_WANT},
		// largest lacing value, then trailing noise only
		'{0, 0, 1, 64'h8000_0000_0000_0000, 1, 255, 1, 8'd2, 32'd32000, 0, 0, 0, 0, NO_WANT},
		'{4, 0, 0, 64'd0, 0, 0, 0, 8'd0, 32'd0, 0, 0, 1, 0, NO_WANT},
		'{0, 0, 1, 64'd42, 255, 0, 0, 8'd0, 32'd0, 0, 0, 1, 1,
			{ST_NO_ID, 8'd0, 32'd0, 63'd42, 1'b1}},
		// smallest positive granule
		'{0, 0, 1, 64'd1, 0, 0, 0, 8'd0, 32'd0, 0, 0, 1, 1,
			{ST_NO_ID, 8'd0, 32'd0, 63'd1, 1'b1}},
		// stream ends inside the header
		'{0, 0, 1, 64'd5, 0, 0, 0, 8'd0, 32'd0, 20, 0, 1, 1, EMPTY_STREAM}
	};

	// Scanner model state
	phase_t      scan_at;
	logic [23:0] hunt_window;
	logic [4:0]  hdr_pos;
	logic [7:0]  seg_total;
	logic [7:0]  seg_got;
	logic [15:0] body_size;
	logic [15:0] body_got;
	logic [63:0] page_granule;
	logic        marker_match;
	logic [7:0]  page_chans;
	logic [31:0] page_rate;
	logic        have_id;
	logic [7:0]  stream_chans;
	logic [31:0] stream_rate;
	logic [62:0] stream_total;
	logic        stream_total_seen;

	result_t     reports_due[$];
	logic [7:0]  stream_q[$];

	int  fails;
	int  cycle_count;
	int  bytes_sent;
	int  streams_sent;
	int  reports_seen;
	int  seen_ok;
	int  seen_no_id;
	int  seen_zero;
	int  seen_total;
	bit  jitter_on;
	bit  calm;
	int  sink_hold;
	result_t mon_want;
	result_t mon_got;

	function automatic void clear_scanner();
		scan_at           = PH_HUNT;
		hunt_window       = '0;
		hdr_pos           = '0;
		seg_total         = '0;
		seg_got           = '0;
		body_size         = '0;
		body_got          = '0;
		page_granule      = '0;
		marker_match      = 1'b0;
		page_chans        = '0;
		page_rate         = '0;
		have_id           = 1'b0;
		stream_chans      = '0;
		stream_rate       = '0;
		stream_total      = '0;
		stream_total_seen = 1'b0;
	endfunction

	// A page that arrived in full keeps its granule and maybe its identification
	function automatic void finish_page();
		if (page_granule != 64'd0 && !page_granule[63]) begin
			stream_total      = page_granule[62:0];
			stream_total_seen = 1'b1;
		end
		if (!have_id && marker_match && body_size >= ID_MIN_BODY) begin
			stream_chans = page_chans;
			stream_rate  = page_rate;
			have_id      = 1'b1;
		end
		scan_at     = PH_HUNT;
		hunt_window = '0;
	endfunction

	function automatic void open_body();
		body_got     = '0;
		marker_match = 1'b1;
		page_chans   = '0;
		page_rate    = '0;
		if (body_size == 16'd0) begin
			finish_page();
		end else begin
			scan_at = PH_BODY;
		end
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		case (scan_at)
			PH_VERSION: begin
				if (b == 8'h00) begin
					scan_at      = PH_HEADER;
					hdr_pos      = HDR_FIRST_IDX;
					page_granule = '0;
				end else begin
					scan_at     = PH_HUNT;
					hunt_window = {16'h0000, b};
				end
			end
			PH_HEADER: begin
				if (hdr_pos >= GRANULE_LO_IDX && hdr_pos <= GRANULE_HI_IDX) begin
					page_granule = page_granule
						| (64'(b) << (8 * int'(hdr_pos - GRANULE_LO_IDX)));
				end
				if (hdr_pos >= SEG_COUNT_IDX) begin
					seg_total = b;
					seg_got   = '0;
					body_size = '0;
					if (b == 8'd0) begin
						open_body();
					end else begin
						scan_at = PH_SEGS;
					end
				end else begin
					hdr_pos = hdr_pos + 5'd1;
				end
			end
			PH_SEGS: begin
				body_size = body_size + 16'(b);
				seg_got   = seg_got + 8'd1;
				if (seg_got >= seg_total) begin
					open_body();
				end
			end
			PH_BODY: begin
				if (body_got < ID_MARKER_LEN) begin
					if (b != VORBIS_TAG[8 * int'(body_got) +: 8]) begin
						marker_match = 1'b0;
					end
				end
				if (body_got == ID_CHAN_IDX) begin
					page_chans = b;
				end
				if (body_got >= ID_RATE_LO_IDX && body_got <= ID_RATE_HI_IDX) begin
					page_rate = page_rate | (32'(b) << (8 * int'(body_got - ID_RATE_LO_IDX)));
				end
				body_got = body_got + 16'd1;
				if (body_got >= body_size) begin
					finish_page();
				end
			end
			default: begin
				scan_at = PH_HUNT;
				if (hunt_window == CAPTURE_PREFIX && b == CAPTURE_LAST) begin
					scan_at     = PH_VERSION;
					hunt_window = '0;
				end else begin
					hunt_window = {hunt_window[15:0], b};
				end
			end
		endcase
	endfunction

	// Advance the model by one byte; returns 1 with the report on the last byte
	function automatic bit scan_and_report(input logic [7:0] b, input logic last,
			output result_t rep);
		rep = '0;
		scan_byte(b);
		if (!last) begin
			return 1'b0;
		end
		if (!have_id) begin
			rep.status = ST_NO_ID;
		end else if (stream_chans == 8'd0 || stream_rate == 32'd0) begin
			rep.status = ST_ZERO_PARAM;
		end else begin
			rep.status = ST_OK;
		end
		rep.channel_count = stream_chans;
		rep.sample_rate   = stream_rate;
		rep.total_samples = stream_total_seen ? stream_total : 63'd0;
		rep.total_known   = stream_total_seen;
		clear_scanner();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (fails < PRINT_CAP) begin
			$display("mismatch at cycle %0d, report %0d, %s: got 0x%0h, expected 0x%0h",
				cycle_count, reports_seen, what, got, want);
		end
		fails++;
	endtask

	// One byte transaction, with an occasional idle burst in front
	task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
			input result_t want);
		result_t rep;
		if (jitter_on && !calm && $urandom_range(0, 4) == 0) begin
			s_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= b;
		s_last  <= last;
		@(posedge clk);
		while (!s_ready) @(posedge clk);
		bytes_sent++;
		if (scan_and_report(b, last, rep)) begin
			reports_due.push_back(typed ? want : rep);
		end
	endtask

	task automatic play_stream(input bit typed, input result_t want);
		int i;
		for (i = 0; i < stream_q.size(); i++) begin
			push_byte(stream_q[i], i == stream_q.size() - 1, typed, want);
		end
		stream_q.delete();
		streams_sent++;
	endtask

	// Hold the input side until every outstanding report has been taken
	task automatic drain();
		s_valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
	endtask

	task automatic add_noise(input int count);
		if ($urandom_range(0, 2) == 0) begin
			// capture prefix with no final 'S'
			stream_q.push_back(CAPTURE_PREFIX[23:16]);
			stream_q.push_back(CAPTURE_PREFIX[15:8]);
			stream_q.push_back(CAPTURE_PREFIX[7:0]);
		end
		repeat (count) stream_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_bad_version(input logic [7:0] ver);
		stream_q.push_back(CAPTURE_PREFIX[23:16]);
		stream_q.push_back(CAPTURE_PREFIX[15:8]);
		stream_q.push_back(CAPTURE_PREFIX[7:0]);
		stream_q.push_back(CAPTURE_LAST);
		stream_q.push_back(ver);
	endtask

	// Header, segment table and body of one page
	task automatic add_page(input logic [63:0] gran, input int nseg, input int seg_max,
			input bit vary_segs, input bit id_pkt, input logic [7:0] chans,
			input logic [31:0] rate, input bit o_given);
		int         blen;
		int         i;
		logic [7:0] seg;
		blen = 0;
		if (!o_given) begin
			stream_q.push_back(CAPTURE_PREFIX[23:16]);
		end
		stream_q.push_back(CAPTURE_PREFIX[15:8]);
		stream_q.push_back(CAPTURE_PREFIX[7:0]);
		stream_q.push_back(CAPTURE_LAST);
		stream_q.push_back(8'h00);
		stream_q.push_back(8'($urandom_range(0, 7)));   // header type flags
		for (i = 0; i < 8; i++) begin
			stream_q.push_back(gran[8 * i +: 8]);
		end
		repeat (12) stream_q.push_back(8'($urandom_range(0, 255)));  // serial, seq, crc
		stream_q.push_back(8'(nseg));
		for (i = 0; i < nseg; i++) begin
			seg = vary_segs ? 8'($urandom_range(0, seg_max)) : 8'(seg_max);
			blen += int'(seg);
			stream_q.push_back(seg);
		end
		for (i = 0; i < blen; i++) begin
			if (id_pkt && i < 7) begin
				stream_q.push_back(VORBIS_TAG[8 * i +: 8]);
			end else if (id_pkt && i == 11) begin
				stream_q.push_back(chans);
			end else if (id_pkt && i >= 12 && i <= 15) begin
				stream_q.push_back(rate[8 * (i - 12) +: 8]);
			end else begin
				stream_q.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Mostly well-formed pages with random content, some noise and damage
	task automatic random_stream();
		int          pages;
		int          k;
		int          start;
		int          nseg;
		int          seg_max;
		bit          id_pkt;
		bit          o_given;
		logic [7:0]  ver;
		logic [63:0] gran;
		logic [7:0]  chans;
		logic [31:0] rate;
		pages = $urandom_range(0, 3);
		if (pages == 0 || $urandom_range(0, 3) == 0) begin
			add_noise($urandom_range(1, 8));
		end
		for (k = 0; k < pages; k++) begin
			case ($urandom_range(0, 3))
				0:       gran = '0;
				1:       gran = {$urandom, $urandom};
				2:       gran = 64'($urandom_range(1, 100000));
				default: gran = {1'b1, 31'($urandom), $urandom};
			endcase
			id_pkt = ($urandom_range(0, 2) == 0);
			chans  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(1, 8));
			rate   = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
			if (id_pkt) begin
				nseg    = $urandom_range(1, 2);
				seg_max = $urandom_range(8, 28);
			end else if ($urandom_range(0, 19) == 0) begin
				nseg    = $urandom_range(100, 255);
				seg_max = $urandom_range(0, 2);
			end else begin
				nseg    = $urandom_range(0, 4);
				seg_max = $urandom_range(0, 12);
			end
			o_given = 1'b0;
			if ($urandom_range(0, 7) == 0) begin
				o_given = ($urandom_range(0, 1) == 0);
				ver     = o_given ? CAPTURE_PREFIX[23:16] : 8'($urandom_range(1, 255));
				add_bad_version(ver);
			end
			start = stream_q.size();
			add_page(gran, nseg, seg_max, 1'b1, id_pkt, chans, rate, o_given);
			if ($urandom_range(0, 9) == 0) begin
				stream_q[start + $urandom_range(0, stream_q.size() - start - 1)] ^=
					8'($urandom_range(1, 255));
			end
			if ($urandom_range(0, 3) == 0) begin
				add_noise($urandom_range(1, 5));
			end
		end
		// sometimes the stream stops partway
		if ($urandom_range(0, 4) == 0 && stream_q.size() > 1) begin
			repeat ($urandom_range(1, stream_q.size() - 1)) void'(stream_q.pop_back());
		end
		if (stream_q.size() == 0) begin
			stream_q.push_back(8'($urandom_range(0, 255)));
		end
		play_stream(1'b0, NO_WANT);
	endtask

	// Report check, output-side stalls and the cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d reports outstanding",
				cycle_count, reports_due.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			if (arst_n && m_valid && m_ready) begin
				reports_seen++;
				if (reports_due.size() == 0) begin
					report_mismatch("report with none expected", m_data[63:0], 64'd0);
				end else begin
					mon_want = reports_due.pop_front();
					mon_got.status        = m_data[1:0];
					mon_got.channel_count = m_data[9:2];
					mon_got.sample_rate   = m_data[41:10];
					mon_got.total_samples = m_data[104:42];
					mon_got.total_known   = m_user;
					if (mon_got.status !== mon_want.status)
						report_mismatch("status", mon_got.status, mon_want.status);
					if (mon_got.channel_count !== mon_want.channel_count)
						report_mismatch("channel_count", mon_got.channel_count,
							mon_want.channel_count);
					if (mon_got.sample_rate !== mon_want.sample_rate)
						report_mismatch("sample_rate", mon_got.sample_rate,
							mon_want.sample_rate);
					if (mon_got.total_samples !== mon_want.total_samples)
						report_mismatch("total_samples", mon_got.total_samples,
							mon_want.total_samples);
					if (mon_got.total_known !== mon_want.total_known)
						report_mismatch("total_known", mon_got.total_known,
							mon_want.total_known);
					case (mon_want.status)
						ST_OK:    seen_ok++;
						ST_NO_ID: seen_no_id++;
						default:  seen_zero++;
					endcase
					if (mon_want.total_known) seen_total++;
				end
			end
			// ready is held low in random bursts while jitter is on and the bench is not calm
			if (calm || !jitter_on) begin
				sink_hold = 0;
				m_ready  <= 1'b1;
			end else if (sink_hold > 0) begin
				sink_hold--;
				m_ready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				sink_hold = $urandom_range(1, 4) - 1;
				m_ready  <= 1'b0;
			end else begin
				m_ready <= 1'b1;
			end
		end
	end

	// Reset, directed streams, random streams, wind-down
	initial begin
		int r;
		int n;
		int rand_start;
		clear_scanner();
		fails        = 0;
		cycle_count  = 0;
		bytes_sent   = 0;
		streams_sent = 0;
		reports_seen = 0;
		seen_ok      = 0;
		seen_no_id   = 0;
		seen_zero    = 0;
		seen_total   = 0;
		sink_hold    = 0;
		calm         = 1'b0;
		jitter_on    = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < $size(plan); r++) begin
			repeat (plan[r].junk) stream_q.push_back(8'($urandom_range(0, 255)));
			if (plan[r].bad_ver) begin
				add_bad_version(CAPTURE_PREFIX[23:16]);
			end
			if (plan[r].page) begin
				add_page(plan[r].gran, plan[r].nseg, plan[r].seg, 1'b0, plan[r].id_pkt,
					plan[r].chans, plan[r].rate, plan[r].bad_ver);
			end
			repeat (plan[r].cut) void'(stream_q.pop_back());
			repeat (plan[r].tail) stream_q.push_back(8'($urandom_range(0, 255)));
			if (plan[r].ends) begin
				play_stream(plan[r].typed, plan[r].want);
			end
		end
		drain();

		rand_start = bytes_sent;
		for (n = 0; n < RAND_STREAMS || bytes_sent - rand_start < RAND_BYTES; n++) begin
			calm      = (n >= RAND_STREAMS - 6);
			jitter_on = !calm && ($urandom_range(0, 3) != 0);
			if (n == RAND_STREAMS / 2) begin
				drain();
			end
			random_stream();
		end

		s_valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d streams, %0d bytes, %0d reports checked", streams_sent,
			bytes_sent, reports_seen);
		$display("reports: ok %0d, no identification %0d, zero parameter %0d; %0d with a total",
			seen_ok, seen_no_id, seen_zero, seen_total);
		if (fails == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/ovps_pkg.sv
hdl/ovps_in_stage.sv
hdl/ovps_parser.sv
hdl/ovps_out_stage.sv
hdl/ogg_vorbis_page_scanner_top.sv
tb/tb_ogg_vorbis_page_scanner_top.sv
